[hw/rtl/fqp_pkg.sv]
// shared types and constants of the fastq record parser
package fqp_pkg;

  // limits
  localparam logic [15:0] MAX_SEQ_LEN = 16'hFFFF;
  localparam logic [7:0]  MAX_ID_LEN  = 8'hFF;

  // result kinds
  localparam logic [2:0] KIND_ID   = 3'd0;
  localparam logic [2:0] KIND_BASE = 3'd1;
  localparam logic [2:0] KIND_QUAL = 3'd2;
  localparam logic [2:0] KIND_END  = 3'd3;
  localparam logic [2:0] KIND_ERR  = 3'd4;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_NO_AT      = 3'd1;
  localparam logic [2:0] ERR_SEQ_AT     = 3'd2;
  localparam logic [2:0] ERR_QUAL_LONG  = 3'd3;
  localparam logic [2:0] ERR_QUAL_SHORT = 3'd4;
  localparam logic [2:0] ERR_EARLY_END  = 3'd5;
  localparam logic [2:0] ERR_ID_LONG    = 3'd6;
  localparam logic [2:0] ERR_SEQ_LONG   = 3'd7;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } fqp_in_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic [7:0]  out_byte;
    logic [15:0] out_length;
    logic [2:0]  out_error;
    logic        out_last;
  } fqp_out_t;

  // results of one byte, handed from the parser core to the result queue
  typedef struct packed {
    logic [1:0] cnt;
    fqp_out_t   res0;
    fqp_out_t   res1;
  } fqp_push_t;

endpackage

[hw/rtl/fastq_record_parser_top.sv]
// top level of the fastq record parser
// Takes one FASTQ byte (or an end-of-input mark) per transfer on the in_
// channel and returns identifier bytes, bases, quality bytes, record ends
// with their sequence length, and error codes on the out_ channel, each
// result with out_last set on the final result of its byte. A byte is
// taken in every cycle in which in_stall is low: it sits in the input
// register while the parser core decides its results and the next parser
// state, and those results are written into a four-entry result queue.
// The queue drains one result per cycle while out_stall is low, which
// sets the sustained rate: one byte per cycle, except that an identifier
// byte following an interior whitespace run yields two results (a space
// and the byte) and so takes an extra output slot. in_stall rises only
// when the queue lacks room for two more results. After an error the
// parser stays silent until the end-of-input mark, which closes the
// record and returns the parser to its reset state.
module fastq_record_parser_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fqp_pkg::fqp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output fqp_pkg::fqp_out_t out_data
);
  import fqp_pkg::*;

  // input register
  logic      in_valid_r;
  fqp_in_t   in_item_r;
  logic      room;
  logic      advance;
  fqp_push_t push;

  // the held byte moves into the core when the queue can take both results
  assign advance  = in_valid_r && room;
  assign in_stall = in_valid_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  // payload holds no reset
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) in_item_r <= in_data;
  end

  fqp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_item_r),
    .push    (push)
  );

  fqp_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_push_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |-> push.cnt == 2'd0)
    else $error("results pushed without a byte in the core");

  a_stall_means_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_valid_r)
    else $error("input register lost its byte while stalled");

  a_first_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_valid_r)
    else $error("transfer did not load the input register");

endmodule

[hw/rtl/fqp_core.sv]
// parser state and per-byte next-state and result logic
module fqp_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  fqp_pkg::fqp_in_t item,
  output fqp_pkg::fqp_push_t push
);
  import fqp_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_ID,
    PH_SEQ,
    PH_QUAL,
    PH_ERR
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        lhc_r, lhc_nxt;          // line has content
  logic        skip_r, skip_nxt;
  logic        pend_r, pend_nxt;        // pending interior space
  logic [15:0] seq_r, seq_nxt;
  logic [15:0] qual_r, qual_nxt;
  logic [7:0]  id_r, id_nxt;
  logic        rep_r, rep_nxt;          // record end already reported
  logic        qla_r, qla_nxt;          // quality line started with '@'
  fqp_push_t   push_c;

  function automatic fqp_out_t mk(input logic [2:0] kind, input logic [7:0] b,
                                  input logic [15:0] len, input logic [2:0] err);
    fqp_out_t r;
    r.out_kind   = kind;
    r.out_byte   = b;
    r.out_length = len;
    r.out_error  = err;
    r.out_last   = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic [7:0] b;
    logic       ws;
    logic       first;
    logic       sp;
    logic [8:0] id_sum;
    logic       qla_eff;
    b       = item.in_byte;
    ws      = (b == 8'h20) || (b == 8'h09) || (b == 8'h0B) || (b == 8'h0C) || (b == 8'h0D);
    first   = !lhc_r;
    sp      = pend_r && (id_r != 8'd0);
    id_sum  = {1'b0, id_r} + (sp ? 9'd2 : 9'd1);
    qla_eff = first ? (b == "@") : qla_r;

    phase_nxt = phase_r;
    lhc_nxt   = lhc_r;
    skip_nxt  = skip_r;
    pend_nxt  = pend_r;
    seq_nxt   = seq_r;
    qual_nxt  = qual_r;
    id_nxt    = id_r;
    rep_nxt   = rep_r;
    qla_nxt   = qla_r;
    push_c    = '0;

    if (item.end_of_input) begin
      if (phase_r == PH_ID || phase_r == PH_SEQ) begin
        push_c.cnt  = 2'd1;
        push_c.res0 = mk(KIND_ERR, 8'd0, 16'd0, ERR_EARLY_END);
      end else if (phase_r == PH_QUAL) begin
        if (qual_r != seq_r) begin
          push_c.cnt  = 2'd1;
          push_c.res0 = mk(KIND_ERR, 8'd0, 16'd0, ERR_QUAL_SHORT);
        end else if (!rep_r) begin
          push_c.cnt  = 2'd1;
          push_c.res0 = mk(KIND_END, 8'd0, seq_r, ERR_NONE);
        end
      end
      phase_nxt = PH_WAIT;
      lhc_nxt   = 1'b0;
      skip_nxt  = 1'b0;
      pend_nxt  = 1'b0;
      seq_nxt   = '0;
      qual_nxt  = '0;
      id_nxt    = '0;
      rep_nxt   = 1'b0;
      qla_nxt   = 1'b0;
    end else if (b == 8'h0A) begin
      if (phase_r != PH_ERR) begin
        if (phase_r == PH_ID) begin
          phase_nxt = PH_SEQ;
        end else if (phase_r == PH_QUAL && qual_r == seq_r && !rep_r) begin
          rep_nxt     = 1'b1;
          push_c.cnt  = 2'd1;
          push_c.res0 = mk(KIND_END, 8'd0, seq_r, ERR_NONE);
        end
        lhc_nxt  = 1'b0;
        skip_nxt = 1'b0;
        pend_nxt = 1'b0;
      end
    end else if (phase_r != PH_ERR && !skip_r) begin
      if (ws) begin
        if (lhc_r) pend_nxt = 1'b1;
      end else begin
        lhc_nxt = 1'b1;
        if (first && b == "#") begin
          skip_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          unique case (phase_r)
            PH_WAIT: begin
              if (b == "@") begin
                phase_nxt = PH_ID;
                id_nxt    = '0;
                seq_nxt   = '0;
                qual_nxt  = '0;
                rep_nxt   = 1'b0;
              end else begin
                phase_nxt   = PH_ERR;
                push_c.cnt  = 2'd1;
                push_c.res0 = mk(KIND_ERR, 8'd0, 16'd0, ERR_NO_AT);
              end
            end
            PH_ID: begin
              if (id_sum > {1'b0, MAX_ID_LEN}) begin
                phase_nxt   = PH_ERR;
                push_c.cnt  = 2'd1;
                push_c.res0 = mk(KIND_ERR, 8'd0, 16'd0, ERR_ID_LONG);
              end else begin
                if (sp) begin
                  push_c.cnt  = 2'd2;
                  push_c.res0 = mk(KIND_ID, 8'h20, 16'd0, ERR_NONE);
                  push_c.res1 = mk(KIND_ID, b, 16'd0, ERR_NONE);
                end else begin
                  push_c.cnt  = 2'd1;
                  push_c.res0 = mk(KIND_ID, b, 16'd0, ERR_NONE);
                end
                id_nxt = id_sum[7:0];
              end
            end
            PH_SEQ: begin
              if (first && b == "@") begin
                phase_nxt   = PH_ERR;
                push_c.cnt  = 2'd1;
                push_c.res0 = mk(KIND_ERR, 8'd0, 16'd0, ERR_SEQ_AT);
              end else if (first && b == "+") begin
                phase_nxt = PH_QUAL;
                qual_nxt  = '0;
                rep_nxt   = 1'b0;
                skip_nxt  = 1'b1;
              end else if (seq_r >= MAX_SEQ_LEN) begin
                phase_nxt   = PH_ERR;
                push_c.cnt  = 2'd1;
                push_c.res0 = mk(KIND_ERR, 8'd0, 16'd0, ERR_SEQ_LONG);
              end else begin
                push_c.cnt  = 2'd1;
                push_c.res0 = mk(KIND_BASE, b, 16'd0, ERR_NONE);
                seq_nxt     = seq_r + 16'd1;
              end
            end
            PH_QUAL: begin
              if (first) qla_nxt = qla_eff;
              if (first && qual_r == seq_r) begin
                if (b == "@") begin
                  phase_nxt = PH_ID;
                  id_nxt    = '0;
                  seq_nxt   = '0;
                  qual_nxt  = '0;
                  rep_nxt   = 1'b0;
                end else begin
                  phase_nxt   = PH_ERR;
                  push_c.cnt  = 2'd1;
                  push_c.res0 = mk(KIND_ERR, 8'd0, 16'd0, ERR_QUAL_LONG);
                end
              end else if (qual_r >= seq_r) begin
                phase_nxt   = PH_ERR;
                push_c.cnt  = 2'd1;
                push_c.res0 = mk(KIND_ERR, 8'd0, 16'd0,
                                 qla_eff ? ERR_QUAL_SHORT : ERR_QUAL_LONG);
              end else begin
                push_c.cnt  = 2'd1;
                push_c.res0 = mk(KIND_QUAL, b, 16'd0, ERR_NONE);
                qual_nxt    = qual_r + 16'd1;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end

    // mark the final result of this byte
    if (push_c.cnt == 2'd1) push_c.res0.out_last = 1'b1;
    if (push_c.cnt == 2'd2) push_c.res1.out_last = 1'b1;
    if (!advance) push_c.cnt = 2'd0;
  end

  assign push = push_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      lhc_r   <= 1'b0;
      skip_r  <= 1'b0;
      pend_r  <= 1'b0;
      seq_r   <= '0;
      qual_r  <= '0;
      id_r    <= '0;
      rep_r   <= 1'b0;
      qla_r   <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      lhc_r   <= lhc_nxt;
      skip_r  <= skip_nxt;
      pend_r  <= pend_nxt;
      seq_r   <= seq_nxt;
      qual_r  <= qual_nxt;
      id_r    <= id_nxt;
      rep_r   <= rep_nxt;
      qla_r   <= qla_nxt;
    end
  end

  a_pair_is_space: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> phase_r == PH_ID && push.res0.out_kind == KIND_ID &&
                        push.res0.out_byte == 8'h20 && !push.res0.out_last &&
                        push.res1.out_last)
    else $error("two results from one byte that is not a spaced id byte");

  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    advance && phase_r == PH_ERR && !item.end_of_input |-> push.cnt == 2'd0)
    else $error("result produced in error state");

  a_qual_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_QUAL |-> qual_r <= seq_r)
    else $error("quality count beyond sequence length");

endmodule

[hw/rtl/fqp_out_fifo.sv]
// small result queue taking up to two results per cycle, one out per cycle while out_stall is low
module fqp_out_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  fqp_pkg::fqp_push_t push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output fqp_pkg::fqp_out_t  out_data
);
  import fqp_pkg::*;

  fqp_out_t             mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0]   count_r;
  logic                 pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign room      = (count_r <= FIFO_CW'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_ptr_r] <= push.res0;
    if (push.cnt == 2'd2) mem_r[wr_ptr_r + FIFO_AW'(1)] <= push.res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(push.cnt);
      if (pop) rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      count_r <= count_r + FIFO_CW'(push.cnt) - FIFO_CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> count_r <= FIFO_CW'(FIFO_DEPTH - 2))
    else $error("result queue written without room");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue count out of range");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    pop && push.cnt == 2'd0 |=> count_r == $past(count_r) - FIFO_CW'(1))
    else $error("result queue count did not follow a pop");

endmodule

[sim/fqp_tracker_pkg.sv]
// result predictor and checker for the fastq record parser test
package fqp_tracker_pkg;
  import fqp_pkg::*;

  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_AT   = 8'h40;

  typedef enum logic [2:0] {WAIT_HDR, IN_ID, IN_SEQ, IN_QUAL, HALTED} parse_phase_t;

  class record_tracker;
    parse_phase_t phase;
    bit           line_has_content;
    bit           skip_line;
    bit           pending_space;
    bit           record_reported;
    bit           qual_line_at;
    int unsigned  seq_count;
    int unsigned  qual_count;
    int unsigned  id_count;

    fqp_out_t     awaited[$];
    fqp_out_t     step_out[$];

    int           failures;
    int           bytes_seen;
    int           results_checked;
    int           record_ends;
    bit [7:0]     errors_seen;

    function new();
      clear_state();
    endfunction

    function void clear_state();
      phase            = WAIT_HDR;
      line_has_content = 1'b0;
      skip_line        = 1'b0;
      pending_space    = 1'b0;
      record_reported  = 1'b0;
      qual_line_at     = 1'b0;
      seq_count        = 0;
      qual_count       = 0;
      id_count         = 0;
    endfunction

    function void queue_result(logic [2:0] kind, logic [7:0] b, logic [15:0] len,
                               logic [2:0] code);
      fqp_out_t r;
      r.out_kind   = kind;
      r.out_byte   = b;
      r.out_length = len;
      r.out_error  = code;
      r.out_last   = 1'b0;
      step_out.push_back(r);
    endfunction

    function void halt_with(logic [2:0] code);
      phase = HALTED;
      queue_result(KIND_ERR, 8'h00, 16'h0000, code);
    endfunction

    function void open_record();
      phase           = IN_ID;
      id_count        = 0;
      seq_count       = 0;
      qual_count      = 0;
      record_reported = 1'b0;
      pending_space   = 1'b0;
    endfunction

    function void close_line();
      if (phase == IN_ID) begin
        phase = IN_SEQ;
      end else if (phase == IN_QUAL && qual_count == seq_count && !record_reported) begin
        record_reported = 1'b1;
        queue_result(KIND_END, 8'h00, 16'(seq_count), ERR_NONE);
      end
      line_has_content = 1'b0;
      skip_line        = 1'b0;
      pending_space    = 1'b0;
    endfunction

    function void take_content(logic [7:0] b, bit first);
      bit          sp;
      int unsigned need;
      if (first && b == CH_HASH) begin
        skip_line = 1'b1;
        return;
      end
      case (phase)
        WAIT_HDR: begin
          if (b == CH_AT) open_record();
          else halt_with(ERR_NO_AT);
        end
        IN_ID: begin
          sp   = pending_space && id_count > 0;
          need = sp ? 2 : 1;
          if (id_count + need > MAX_ID_LEN) begin
            halt_with(ERR_ID_LONG);
          end else begin
            if (sp) queue_result(KIND_ID, CH_SP, 16'h0000, ERR_NONE);
            queue_result(KIND_ID, b, 16'h0000, ERR_NONE);
            id_count += need;
          end
        end
        IN_SEQ: begin
          if (first && b == CH_AT) begin
            halt_with(ERR_SEQ_AT);
          end else if (first && b == CH_PLUS) begin
            phase           = IN_QUAL;
            qual_count      = 0;
            record_reported = 1'b0;
            skip_line       = 1'b1;
          end else if (seq_count >= MAX_SEQ_LEN) begin
            halt_with(ERR_SEQ_LONG);
          end else begin
            queue_result(KIND_BASE, b, 16'h0000, ERR_NONE);
            seq_count++;
          end
        end
        IN_QUAL: begin
          if (first) qual_line_at = (b == CH_AT);
          if (first && qual_count == seq_count) begin
            if (b == CH_AT) open_record();
            else halt_with(ERR_QUAL_LONG);
          end else if (qual_count >= seq_count) begin
            halt_with(qual_line_at ? ERR_QUAL_SHORT : ERR_QUAL_LONG);
          end else begin
            queue_result(KIND_QUAL, b, 16'h0000, ERR_NONE);
            qual_count++;
          end
        end
        default: ;
      endcase
      pending_space = 1'b0;
    endfunction

    // predicts the results of one accepted byte and queues them
    function void absorb_byte(fqp_in_t item);
      logic [7:0] b;
      bit         first;
      b = item.in_byte;
      step_out.delete();
      bytes_seen++;
      if (item.end_of_input) begin
        if (phase != HALTED) begin
          close_line();
          if (phase == IN_ID || phase == IN_SEQ) halt_with(ERR_EARLY_END);
          else if (phase == IN_QUAL && qual_count != seq_count) halt_with(ERR_QUAL_SHORT);
        end
        clear_state();
      end else if (b == CH_NL) begin
        if (phase != HALTED) close_line();
      end else if (phase != HALTED && !skip_line) begin
        if (b inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D}) begin
          if (line_has_content) pending_space = 1'b1;
        end else begin
          first            = !line_has_content;
          line_has_content = 1'b1;
          take_content(b, first);
        end
      end
      if (step_out.size() != 0) step_out[step_out.size() - 1].out_last = 1'b1;
      foreach (step_out[i]) awaited.push_back(step_out[i]);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s expected %0d actual %0d", name, want, got);
        failures++;
      end
    endfunction

    // checks one result against the oldest prediction
    function void match_result(fqp_out_t got);
      fqp_out_t want;
      if (awaited.size() == 0) begin
        $error("result kind %0d byte %0d arrived with nothing predicted",
               got.out_kind, got.out_byte);
        failures++;
        return;
      end
      want = awaited.pop_front();
      results_checked++;
      if (want.out_kind == KIND_END) record_ends++;
      if (want.out_kind == KIND_ERR) errors_seen[want.out_error] = 1'b1;
      compare_field("out_kind", 16'(want.out_kind), 16'(got.out_kind));
      compare_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
      compare_field("out_length", want.out_length, got.out_length);
      compare_field("out_error", 16'(want.out_error), 16'(got.out_error));
      compare_field("out_last", 16'(want.out_last), 16'(got.out_last));
    endfunction
  endclass

endpackage

[sim/fastq_record_parser_top_test.sv]
// testbench of the fastq record parser top level: random FASTQ files, predicted results
module fastq_record_parser_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fqp_pkg::*;
  import fqp_tracker_pkg::*;

  localparam int TOTAL_ITEMS  = 1350;
  localparam int HOLD_CYCLES  = 80;   // long receiver hold-off
  localparam int QUIET_LIMIT  = 1000; // cycles without any transfer before giving up
  localparam int TAIL_CYCLES  = 16;   // input register plus result queue, with margin

  // which bytes may open a content line
  typedef enum logic [1:0] {LEAD_ANY, LEAD_NO_HASH, LEAD_PLAIN} lead_rule_t;

  // ways a record can be broken
  typedef enum logic [2:0] {
    FLAW_NONE, FLAW_NO_AT, FLAW_SEQ_AT, FLAW_QUAL_LONG, FLAW_QUAL_SHORT, FLAW_CUT
  } flaw_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  fqp_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  fqp_out_t out_data;

  record_tracker tracker;

  // sender bookkeeping
  int items_sent = 0;
  int burst_left = 0;
  int files_done = 0;

  // receiver bookkeeping
  int hold_asks = 0;
  int holds_done = 0;
  int hold_left = 0;
  int window_left = 0;
  int stall_pct = 0;

  int quiet = 0;

  fastq_record_parser_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // receiver: stall windows of random length and density, plus a long
  // hold-off whenever the sender asks for one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall   <= 1'b0;
      window_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asks != holds_done) begin
      out_stall  <= 1'b1;
      holds_done <= holds_done + 1;
      hold_left  <= HOLD_CYCLES;
    end else begin
      if (window_left == 0) begin
        window_left <= $urandom_range(4, 60);
        case ($urandom_range(0, 3))
          0: stall_pct <= 0;   // free-running stretch
          1: stall_pct <= 25;
          2: stall_pct <= 50;
          default: stall_pct <= 85;
        endcase
      end else begin
        window_left <= window_left - 1;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // transfer monitors and watchdog; values sampled here are the pre-edge ones
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.absorb_byte(in_data);
      if (out_valid && !out_stall) tracker.match_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, tracker.awaited.size());
        $display("fastq_record_parser_top test failed");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // offer one item and hold it until the transfer; bursts with random gaps
  task automatic put_item(input fqp_in_t item);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    fqp_in_t item;
    item.in_byte      = b;
    item.end_of_input = 1'b0;
    put_item(item);
  endtask

  // end-of-file mark; the byte beside it is ignored by the parser
  task automatic put_eof(input logic [7:0] junk);
    fqp_in_t item;
    item.in_byte      = junk;
    item.end_of_input = 1'b1;
    put_item(item);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_blanks(input int count);
    logic [7:0] pick;
    repeat (count) begin
      case ($urandom_range(0, 4))
        0: pick = 8'h09;
        1: pick = 8'h0B;
        2: pick = 8'h0C;
        3: pick = 8'h0D;
        default: pick = CH_SP;
      endcase
      put_byte(pick);
    end
  endtask

  // any byte but a newline
  function automatic logic [7:0] loose_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == CH_NL) ? CH_SP : b;
  endfunction

  // a content byte, mostly printable, never whitespace
  function automatic logic [7:0] glyph(input lead_rule_t rule);
    logic [7:0] b;
    do begin
      if ($urandom_range(0, 9) == 0) b = 8'($urandom_range(0, 255));
      else b = 8'($urandom_range(33, 126));
    end while (b inside {CH_NL, 8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D} ||
               (rule != LEAD_ANY && b == CH_HASH) ||
               (rule == LEAD_PLAIN && (b == CH_AT || b == CH_PLUS)));
    return b;
  endfunction

  // blank line, whitespace-only line or comment line
  task automatic put_filler();
    case ($urandom_range(0, 2))
      0: ;
      1: put_blanks($urandom_range(1, 3));
      default: begin
        put_byte(CH_HASH);
        repeat ($urandom_range(0, 6)) put_byte(loose_byte());
      end
    endcase
    put_byte(CH_NL);
  endtask

  // one line of content bytes with whitespace at the edges and inside
  task automatic put_content_line(input int count, input lead_rule_t rule);
    if ($urandom_range(0, 5) == 0) put_blanks($urandom_range(1, 2));
    for (int i = 0; i < count; i++) begin
      if (i != 0 && $urandom_range(0, 9) == 0) put_blanks($urandom_range(1, 3));
      put_byte(glyph(i == 0 ? rule : LEAD_ANY));
    end
    if ($urandom_range(0, 5) == 0) put_blanks($urandom_range(1, 2));
    put_byte(CH_NL);
  endtask

  // a multi-line sequence or quality section of a given total size
  task automatic put_section(input int total, input lead_rule_t rule, input int widest);
    int left;
    int n;
    left = total;
    while (left > 0) begin
      n = $urandom_range(1, (left < widest) ? left : widest);
      put_content_line(n, rule);
      left -= n;
      if ($urandom_range(0, 15) == 0) put_filler();
    end
  endtask

  task automatic put_record(input int id_len, input int seq_len, input flaw_t flaw);
    int qual_len;
    if ($urandom_range(0, 3) == 0) put_filler();
    if ($urandom_range(0, 4) == 0) put_blanks($urandom_range(1, 2));
    put_byte(flaw == FLAW_NO_AT ? glyph(LEAD_PLAIN) : CH_AT);
    if ($urandom_range(0, 3) == 0) put_blanks($urandom_range(1, 2));
    for (int i = 0; i < id_len; i++) begin
      if (i != 0 && $urandom_range(0, 5) == 0) put_blanks($urandom_range(1, 3));
      put_byte(glyph(LEAD_ANY));
    end
    if ($urandom_range(0, 3) == 0) put_blanks($urandom_range(1, 2));
    put_byte(CH_NL);
    put_section(seq_len, LEAD_PLAIN, 12);
    if (flaw == FLAW_SEQ_AT) begin
      // a header where the separator line belongs
      put_byte(CH_AT);
      put_content_line($urandom_range(0, 4), LEAD_ANY);
    end else if (flaw == FLAW_CUT && $urandom_range(0, 1) == 0) begin
      // file ends inside the sequence section
    end else begin
      put_byte(CH_PLUS);
      repeat ($urandom_range(0, 4)) put_byte(loose_byte());
      put_byte(CH_NL);
      qual_len = seq_len;
      case (flaw)
        FLAW_QUAL_LONG: qual_len = seq_len + $urandom_range(1, 3);
        FLAW_QUAL_SHORT, FLAW_CUT: qual_len = (seq_len == 0) ? 0 : $urandom_range(0, seq_len - 1);
        default: ;
      endcase
      put_section(qual_len, LEAD_NO_HASH, 12);
    end
  endtask

  // one file: noise, or a few records, ending with the end-of-file mark
  task automatic put_file();
    int    records;
    int    seq_len;
    flaw_t flaw;
    if ($urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(3, 24)) put_byte(8'($urandom_range(0, 255)));
    end else begin
      records = $urandom_range(1, 4);
      for (int r = 0; r < records; r++) begin
        flaw = FLAW_NONE;
        if ($urandom_range(0, 99) >= 70) begin
          repeat ($urandom_range(1, flaw.num() - 1)) flaw = flaw.next();
        end
        seq_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 24);
        if ($urandom_range(0, 19) == 0) seq_len = $urandom_range(25, 60);
        put_record($urandom_range(0, 10), seq_len, flaw);
        if (flaw != FLAW_NONE) begin
          // a following record: a header after a short quality section, or
          // just bytes the parser has to stay silent on
          if (flaw == FLAW_QUAL_SHORT || $urandom_range(0, 1) == 0)
            put_record($urandom_range(0, 6), $urandom_range(0, 8), FLAW_NONE);
          break;
        end
      end
      if ($urandom_range(0, 3) == 0) put_filler();
    end
    put_eof(8'($urandom_range(0, 255)));
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.awaited.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  initial begin
    tracker = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: end of file with no record, identifier whitespace folding,
    // multi-line record with extreme byte values, comment line, end of file
    // after a complete record, missing '@' and silence until end of file
    put_eof(8'hFF);
    put_text("@ a\t b \n");
    put_text("AC\n+x\n");
    put_byte(8'h21);
    put_byte(8'hFF);
    put_byte(CH_NL);
    put_text("#\n");
    put_eof(8'h00);
    put_byte(8'h00);
    put_eof(8'h00);

    // identifier at its limit, then one byte past it
    put_byte(CH_AT);
    repeat (MAX_ID_LEN) put_byte(glyph(LEAD_ANY));
    put_byte(CH_NL);
    put_section(4, LEAD_PLAIN, 12);
    put_text("+\n");
    put_section(4, LEAD_NO_HASH, 12);
    put_byte(CH_AT);
    repeat (int'(MAX_ID_LEN) + 1) put_byte(glyph(LEAD_ANY));
    put_eof(8'($urandom_range(0, 255)));

    // random files; one long receiver hold-off while the sender keeps
    // offering, and regular pauses until everything has come back
    while (items_sent < TOTAL_ITEMS) begin
      if (files_done == 2) begin
        hold_asks  <= hold_asks + 1;
        burst_left = 300;
      end
      if (files_done % 4 == 3) pause_until_drained();
      put_file();
      files_done++;
    end

    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d bytes in %0d files, %0d results checked, %0d record ends",
             tracker.bytes_seen, files_done, tracker.results_checked, tracker.record_ends);
    $display("error codes reported (bit per code): %b", tracker.errors_seen);
    if (tracker.failures == 0 && tracker.awaited.size() == 0) begin
      $display("fastq_record_parser_top test passed");
    end else begin
      $display("fastq_record_parser_top test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/fqp_pkg.sv
hw/rtl/fqp_core.sv
hw/rtl/fqp_out_fifo.sv
hw/rtl/fastq_record_parser_top.sv
sim/fqp_tracker_pkg.sv
sim/fastq_record_parser_top_test.sv
